@@ rtl/core/frame_table_nearest_sequence_lookup_assert.svh @@
// Assertion macros used by the frame table lookup module.
`ifndef FRAME_TABLE_NEAREST_SEQUENCE_LOOKUP_ASSERT_SVH
`define FRAME_TABLE_NEAREST_SEQUENCE_LOOKUP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTNSL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FTNSL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ftnsl_pkg.sv @@
package ftnsl_pkg;

	typedef enum logic [2:0] {
		OP_ADD       = 3'd0,
		OP_NEXT      = 3'd1,
		OP_PREV      = 3'd2,
		OP_EXACT     = 3'd3,
		OP_LAST_SEQ  = 3'd4,
		OP_LAST_TIME = 3'd5,
		OP_CLEAR     = 3'd6
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0]        stream;
		logic signed [63:0] seq;
		logic [63:0]        stamp;
		logic [31:0]        handle;
	} entry_t;

endpackage

@@ rtl/core/frame_table_nearest_sequence_lookup.sv @@
// Frame descriptor table with nearest-sequence lookup. An item is taken when start is high and
// busy is low. Add, clear and the unused opcode answer in the cycle after the item is taken.
// A lookup scans the stored entries one per cycle through the single read port of the table
// memory, then passes through the wait and out states (straight to out when the table is empty),
// and busy stays high until the cycle in which the answer is shown. Each answer is shown for
// exactly one cycle with done high; the receiver cannot hold it off and must capture it in that
// cycle.
`include "frame_table_nearest_sequence_lookup_assert.svh"

module frame_table_nearest_sequence_lookup #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         opcode,
	input  logic [31:0]        stream_id,
	input  logic signed [63:0] seq_num,
	input  logic [63:0]        timestamp,
	input  logic [31:0]        image_handle,
	output logic               done,
	output logic [1:0]         status,
	output logic [31:0]        hit_stream,
	output logic signed [63:0] hit_seq,
	output logic [63:0]        hit_time,
	output logic [31:0]        hit_handle
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_WAIT = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic [IW-1:0]          idx_q;
	logic                   rv_s1;
	logic                   found_q;
	logic                   done_q;
	ftnsl_pkg::opcode_t     op_q;
	logic [31:0]            sid_q;
	logic signed [63:0]     key_q;
	ftnsl_pkg::entry_t      best_q;
	ftnsl_pkg::status_t     status_q;
	ftnsl_pkg::entry_t      hit_q;

	ftnsl_pkg::entry_t      wr_data;
	ftnsl_pkg::entry_t      rd_data;
	logic                   accept;
	logic                   full;
	logic                   wr_en;
	logic                   is_lookup;
	logic                   last_idx;
	logic                   gt_key;
	logic                   lt_key;
	logic                   eq_key;
	logic                   gt_best;
	logic                   lt_best;
	logic                   ge_time;
	logic                   take;
	logic                   take_en;

	assign accept    = start && !busy;
	assign full      = (count_q == CW'(TABLE_DEPTH));
	assign is_lookup = opcode inside {ftnsl_pkg::OP_NEXT, ftnsl_pkg::OP_PREV,
		ftnsl_pkg::OP_EXACT, ftnsl_pkg::OP_LAST_SEQ, ftnsl_pkg::OP_LAST_TIME};
	assign wr_en     = accept && (opcode == ftnsl_pkg::OP_ADD) && !full;
	assign last_idx  = ((CW'(idx_q) + CW'(1)) == count_q);

	assign wr_data.stream = stream_id;
	assign wr_data.seq    = seq_num;
	assign wr_data.stamp  = timestamp;
	assign wr_data.handle = image_handle;

	ftnsl_table #(
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IW-1:0]),
		.wr_data (wr_data),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	always_comb begin
		gt_key  = $signed(rd_data.seq) > key_q;
		lt_key  = $signed(rd_data.seq) < key_q;
		eq_key  = $signed(rd_data.seq) == key_q;
		gt_best = $signed(rd_data.seq) > $signed(best_q.seq);
		lt_best = $signed(rd_data.seq) < $signed(best_q.seq);
		ge_time = rd_data.stamp >= best_q.stamp;
		case (op_q)
			ftnsl_pkg::OP_NEXT:      take = gt_key && (!found_q || lt_best);
			ftnsl_pkg::OP_PREV:      take = lt_key && (!found_q || gt_best);
			ftnsl_pkg::OP_EXACT:     take = eq_key && !found_q;
			ftnsl_pkg::OP_LAST_SEQ:  take = !found_q || gt_best;
			ftnsl_pkg::OP_LAST_TIME: take = !found_q || ge_time;
			default:                 take = 1'b0;
		endcase
		take_en = rv_s1 && (rd_data.stream == sid_q) && take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			rv_s1   <= 1'b0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_OUT) || ((state_q == S_IDLE) && accept && !is_lookup);
			rv_s1  <= (state_q == S_SCAN);
			if (take_en) begin
				found_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						if (is_lookup) begin
							state_q <= (count_q == '0) ? S_OUT : S_SCAN;
						end else begin
							if (opcode == ftnsl_pkg::OP_CLEAR) begin
								count_q <= '0;
							end else if (wr_en) begin
								count_q <= count_q + CW'(1);
							end
						end
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + IW'(1);
					if (last_idx) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= ftnsl_pkg::opcode_t'(opcode);
			sid_q <= stream_id;
			key_q <= seq_num;
			hit_q <= '0;
			case (opcode)
				ftnsl_pkg::OP_ADD:   status_q <= full ? ftnsl_pkg::ST_FULL : ftnsl_pkg::ST_OK;
				ftnsl_pkg::OP_CLEAR: status_q <= ftnsl_pkg::ST_OK;
				default:             status_q <= ftnsl_pkg::ST_MISS;
			endcase
		end
		if (take_en) begin
			best_q <= rd_data;
		end
		if (state_q == S_OUT) begin
			status_q <= found_q ? ftnsl_pkg::ST_OK : ftnsl_pkg::ST_MISS;
			hit_q    <= found_q ? best_q : '0;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign hit_stream = hit_q.stream;
	assign hit_seq    = hit_q.seq;
	assign hit_time   = hit_q.stamp;
	assign hit_handle = hit_q.handle;

	`FTNSL_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(TABLE_DEPTH), "Entry count beyond depth.")
	`FTNSL_ASSERT_SAME(a_scan_in_range, state_q == S_SCAN, CW'(idx_q) < count_q, "Scan past fill.")
	`FTNSL_ASSERT_NEXT(a_lookup_busy, accept && is_lookup, busy, "Lookup taken without busy.")
	`FTNSL_ASSERT_SAME(a_miss_zero, done && status == ftnsl_pkg::ST_MISS,
		hit_seq == '0 && hit_stream == '0 && hit_time == '0, "Miss with non-zero fields.")

endmodule

@@ rtl/core/ftnsl_table.sv @@
module ftnsl_table #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  ftnsl_pkg::entry_t          wr_data,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output ftnsl_pkg::entry_t          rd_data
);

	ftnsl_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
